>>> src/restart_backoff_circuit_breaker_top_defines.svh
// Assertion macros for the restart backoff circuit breaker.
// Used by restart_backoff_circuit_breaker_top; expects clk_i and rst_ni in scope.
`ifndef RESTART_BACKOFF_CIRCUIT_BREAKER_TOP_DEFINES_SVH
`define RESTART_BACKOFF_CIRCUIT_BREAKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define RBCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbcb assertion failed");

// Next-cycle implication.
`define RBCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbcb assertion failed");

`endif

>>> src/rbcb_pkg.sv
// Shared types, register indexes and the backoff selection for the restart supervisor.
// No dependencies.
package rbcb_pkg;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_CRASH      = 3'd1,
    OP_HEARTBEAT  = 3'd2,
    OP_SUCCESS    = 3'd3,
    OP_SET_FLAG   = 3'd4,
    OP_CLEAR_FLAG = 3'd5,
    OP_QUERY      = 3'd6
  } op_e;

  localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd0;
  localparam logic [2:0] REG_SUCCESS_MS   = 3'd1;
  localparam logic [2:0] REG_BACKOFF_LEN  = 3'd2;
  localparam logic [2:0] REG_BACKOFF_0    = 3'd3;
  localparam logic [2:0] REG_BACKOFF_1    = 3'd4;
  localparam logic [2:0] REG_BACKOFF_2    = 3'd5;
  localparam logic [2:0] REG_BACKOFF_3    = 3'd6;

  localparam int unsigned ADDR_BITS = 5;

  typedef logic [3:0][30:0] bo_tab_t;

  typedef struct packed {
    logic [7:0]  crash_limit;
    logic [31:0] stable_ms;
    logic [2:0]  backoff_len;
    bo_tab_t     backoff;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  slot;
    logic [47:0] now_ms;
    logic        enable_policy;
  } req_t;

  typedef struct packed {
    logic        known;
    logic        op_result;
    logic        policy_enabled;
    logic        restart_allowed;
    logic        breaker_open;
    logic        crash_flag;
    logic [7:0]  attempts;
    logic [30:0] backoff_out;
    logic        mark_recovered;
    logic [47:0] restart_in_ms;
    logic [47:0] seen_age_ms;
    logic [38:0] uptime_s;
  } res_t;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [47:0] now_ms;
    logic        enable_policy;
  } item_t;

  function automatic logic [30:0] pick_backoff(logic [7:0] att, logic [2:0] len,
                                               bo_tab_t tab, int unsigned entries);
    logic [2:0] l;
    logic [7:0] idx;
    l = len;
    if (l == 3'd0) l = 3'd1;
    if (32'(l) > entries) l = 3'(entries);
    idx = att - 8'd1;
    if (idx >= 8'(l)) idx = 8'(l) - 8'd1;
    return tab[idx[1:0]];
  endfunction

endpackage

>>> src/rbcb_front.sv
// Front end: takes commands, classifies the event kind and queues them.
// Depends on rbcb_pkg.
module rbcb_front import rbcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  req_t  req_i,
  output logic  busy_o,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  logic  q_pop_i
);

  item_t       fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;
  item_t       item;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_comb begin
    item.slot          = req_i.slot;
    item.now_ms        = req_i.now_ms;
    item.enable_policy = req_i.enable_policy;
    // undefined kinds only report, like a query
    if (req_i.req_type <= OP_QUERY) begin
      item.op = op_e'(req_i.req_type);
    end else begin
      item.op = OP_QUERY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rp_q];

endmodule

>>> src/rbcb_back.sv
// Back end: read-modify-write of one slot record, then result build and
// a digit-by-digit divide for uptime. Depends on rbcb_pkg.
module rbcb_back import rbcb_pkg::*; #(
  parameter int unsigned SLOTS           = 16,
  parameter int unsigned BACKOFF_ENTRIES = 4,
  parameter int unsigned TIME_BITS       = 48
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TB = TIME_BITS;

  // ms to s: x / 1000 = (x >> 3) / 125, long division in 15-bit digits
  localparam int unsigned DW       = 15;
  localparam int unsigned ND       = (TB - 3 + DW - 1) / DW;
  localparam int unsigned YW       = ND * DW;
  localparam int unsigned DGW      = (ND > 1) ? $clog2(ND) : 1;
  localparam logic [6:0]  DIV_ODD  = 7'd125;
  localparam logic [22:0] DIV_RECIP = 23'd4294968;  // ceil(2^29 / 125)
  localparam int unsigned RECIP_SH = 29;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;

  typedef struct packed {
    logic          enabled;
    logic [7:0]    attempts;
    logic          breaker;
    logic          crash;
    logic [TB-1:0] restart;
    logic [TB-1:0] start;
    logic          start_valid;
    logic [TB-1:0] seen;
    logic          seen_valid;
  } rec_t;

  rec_t          mem [SLOTS];
  rec_t          rd_q, rec_q, base, nr;
  item_t         it_q;
  logic [2:0]    state_q;
  logic [SLOTS-1:0] reg_q;
  logic [8:0]    slot_w;
  logic          in_range;
  logic [SW-1:0] idx;
  logic [TB-1:0] now_t, now_q;
  logic          known;
  logic [7:0]    att_inc;
  logic [30:0]   bo_crash;
  logic [TB:0]   sum;
  logic          op_d;
  res_t          res_q, res_base;
  logic          valid_q, valid_d;
  logic          active;
  logic [TB-1:0] el_start, el_seen, to_restart;
  logic [YW-1:0] dv_q;
  logic [6:0]    rem_q, rem_n;
  logic [21:0]   dig_v;
  logic [44:0]   dig_p;
  logic [DW-1:0] qdig;
  logic [38:0]   qt_q, qt_n;
  logic [DGW-1:0] dig_q;
  logic          last_dig;

  assign slot_w   = 9'(it_q.slot);
  assign in_range = slot_w < 9'(SLOTS);
  assign idx      = slot_w[SW-1:0];
  assign now_t    = TB'(it_q.now_ms);
  assign known    = in_range && ((it_q.op == OP_REGISTER) || reg_q[idx]);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  // register clears the record; otherwise work on what was read
  always_comb begin
    if (it_q.op == OP_REGISTER) begin
      base         = '0;
      base.enabled = it_q.enable_policy;
    end else begin
      base = rd_q;
    end
  end

  assign att_inc  = (base.attempts == 8'hFF) ? base.attempts : base.attempts + 8'd1;
  assign bo_crash = pick_backoff(att_inc, cfg_i.backoff_len, cfg_i.backoff, BACKOFF_ENTRIES);
  assign sum      = {1'b0, now_t} + (TB + 1)'(bo_crash);

  always_comb begin
    nr   = base;
    op_d = 1'b0;
    case (it_q.op)
      OP_CRASH: begin
        if (!base.enabled) begin
          nr.breaker = 1'b1;
        end else begin
          nr.attempts    = att_inc;
          nr.start_valid = 1'b0;
          if (att_inc > cfg_i.crash_limit) begin
            nr.breaker = 1'b1;
          end else begin
            nr.restart = sum[TB] ? '1 : sum[TB-1:0];
            op_d       = 1'b1;
          end
        end
      end
      OP_HEARTBEAT: begin
        if (!base.start_valid) begin
          nr.start       = now_t;
          nr.start_valid = 1'b1;
        end
        nr.seen       = now_t;
        nr.seen_valid = 1'b1;
      end
      OP_SUCCESS: begin
        nr.attempts = 8'd0;
        nr.breaker  = 1'b0;
        nr.crash    = 1'b0;
        nr.restart  = '0;
      end
      OP_SET_FLAG: begin
        if (!base.crash) begin
          nr.crash = 1'b1;
          op_d     = 1'b1;
        end
      end
      OP_CLEAR_FLAG: nr.crash = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res_base           = '0;
    res_base.op_result = op_d && known;
    res_base.known     = known;
  end

  assign active     = (rec_q.attempts != 8'd0) && !rec_q.breaker;
  assign el_start   = (now_q >= rec_q.start) ? now_q - rec_q.start : '0;
  assign el_seen    = (now_q >= rec_q.seen) ? now_q - rec_q.seen : '0;
  assign to_restart = (rec_q.restart >= now_q) ? rec_q.restart - now_q : '0;

  // one 15-bit quotient digit per cycle, remainder stays below 125
  assign dig_v    = {rem_q, dv_q[YW-1 -: DW]};
  assign dig_p    = 45'(dig_v) * 45'(DIV_RECIP);
  assign qdig     = dig_p[RECIP_SH +: DW];
  assign rem_n    = 7'(dig_v - 22'(qdig) * 22'(DIV_ODD));
  assign qt_n     = {qt_q[38-DW:0], qdig};
  assign last_dig = (dig_q == DGW'(ND - 1));

  always_comb begin
    case (state_q)
      S_EXEC:  valid_d = !known;
      S_CALC:  valid_d = !rec_q.start_valid;
      S_DIV:   valid_d = last_dig;
      default: valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) rd_q <= mem[idx];
    if (state_q == S_EXEC && known) mem[idx] <= nr;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (q_valid_i) it_q <= q_item_i;
      S_EXEC: begin
        rec_q <= nr;
        now_q <= now_t;
        res_q <= res_base;
      end
      S_CALC: begin
        res_q.policy_enabled   <= rec_q.enabled;
        res_q.restart_allowed  <= rec_q.enabled && !rec_q.breaker && (now_q >= rec_q.restart);
        res_q.breaker_open     <= rec_q.breaker;
        res_q.crash_flag       <= rec_q.crash;
        res_q.attempts         <= rec_q.attempts;
        res_q.backoff_out      <= active ? pick_backoff(rec_q.attempts, cfg_i.backoff_len,
                                                        cfg_i.backoff, BACKOFF_ENTRIES) : '0;
        res_q.mark_recovered   <= rec_q.enabled && active && rec_q.start_valid &&
                                  (el_start >= TB'(cfg_i.stable_ms));
        res_q.restart_in_ms    <= active ? 48'(to_restart) : '0;
        res_q.seen_age_ms      <= rec_q.seen_valid ? 48'(el_seen) : '1;
        dv_q  <= YW'(el_start[TB-1:3]);
        rem_q <= '0;
        qt_q  <= '0;
        dig_q <= '0;
      end
      S_DIV: begin
        dv_q  <= dv_q << DW;
        rem_q <= rem_n;
        qt_q  <= qt_n;
        dig_q <= dig_q + DGW'(1);
        if (last_dig) res_q.uptime_s <= qt_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      reg_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      case (state_q)
        S_IDLE: if (q_valid_i) state_q <= S_READ;
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          if (in_range && it_q.op == OP_REGISTER) reg_q[idx] <= 1'b1;
          state_q <= known ? S_CALC : S_IDLE;
        end
        // no uptime window: quotient stays zero
        S_CALC: state_q <= rec_q.start_valid ? S_DIV : S_IDLE;
        S_DIV:  if (last_dig) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> src/restart_backoff_circuit_breaker_top.sv
// Top level of the restart supervisor: APB policy registers, front queue, back end.
// Depends on rbcb_pkg, rbcb_front, rbcb_back and the defines header.
//
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with res_valid_o, and the receiver
// cannot hold it off. The back end reads the slot record, updates it, builds
// the result and then, for a slot with an uptime window, runs the divide that
// turns uptime in ms into seconds in 15-bit digits; an unknown slot skips the
// result build and the divide. It takes the next command only once it is back
// in idle. A two-entry queue takes new commands meanwhile; busy is high while
// it is full.
// Program the policy registers only while no command is in flight.
`include "restart_backoff_circuit_breaker_top_defines.svh"
module restart_backoff_circuit_breaker_top import rbcb_pkg::*; #(
  parameter int unsigned SLOTS           = 16,
  parameter int unsigned BACKOFF_ENTRIES = 4,
  parameter int unsigned TIME_BITS       = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t  cfg_q;
  logic  wr_en;
  logic  q_valid, q_pop;
  item_t q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crash_limit <= 8'd3;
      cfg_q.stable_ms   <= 32'd60000;
      cfg_q.backoff_len <= 3'd4;
      cfg_q.backoff[0]  <= 31'd100;
      cfg_q.backoff[1]  <= 31'd1000;
      cfg_q.backoff[2]  <= 31'd5000;
      cfg_q.backoff[3]  <= 31'd10000;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_MAX_ATTEMPTS: cfg_q.crash_limit <= pwdata[7:0];
        REG_SUCCESS_MS:   cfg_q.stable_ms   <= pwdata;
        REG_BACKOFF_LEN:  cfg_q.backoff_len <= pwdata[2:0];
        REG_BACKOFF_0:    cfg_q.backoff[0]  <= pwdata[30:0];
        REG_BACKOFF_1:    cfg_q.backoff[1]  <= pwdata[30:0];
        REG_BACKOFF_2:    cfg_q.backoff[2]  <= pwdata[30:0];
        REG_BACKOFF_3:    cfg_q.backoff[3]  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAX_ATTEMPTS: prdata = 32'(cfg_q.crash_limit);
      REG_SUCCESS_MS:   prdata = cfg_q.stable_ms;
      REG_BACKOFF_LEN:  prdata = 32'(cfg_q.backoff_len);
      REG_BACKOFF_0:    prdata = 32'(cfg_q.backoff[0]);
      REG_BACKOFF_1:    prdata = 32'(cfg_q.backoff[1]);
      REG_BACKOFF_2:    prdata = 32'(cfg_q.backoff[2]);
      REG_BACKOFF_3:    prdata = 32'(cfg_q.backoff[3]);
      default:          prdata = 32'd0;
    endcase
  end

  rbcb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  rbcb_back #(
    .SLOTS           (SLOTS),
    .BACKOFF_ENTRIES (BACKOFF_ENTRIES),
    .TIME_BITS       (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  `RBCB_ASSERT_NEXT(a_single_strobe, res_valid_o, !res_valid_o)
  `RBCB_ASSERT_IMPL(a_unknown_zero, res_valid_o && !res_o.known,
                    res_o.attempts == 8'd0 && !res_o.op_result && !res_o.policy_enabled)
  `RBCB_ASSERT_IMPL(a_open_no_backoff, res_valid_o && res_o.breaker_open,
                    res_o.backoff_out == 31'd0 && res_o.restart_in_ms == 48'd0)

endmodule

>>> verif/tb.sv
// Self-checking testbench for restart_backoff_circuit_breaker_top.
// Depends on rbcb_pkg and the block's RTL; predicts every slot snapshot and checks each result.
`timescale 1ns / 1ps

module tb;
  import rbcb_pkg::*;

  localparam int unsigned NSLOT = 16;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_UNDEF = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  restart_backoff_circuit_breaker_top dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // policy and slot records of the predictor
  logic [7:0]  pol_max;
  logic [31:0] pol_stable_ms;
  logic [2:0]  pol_len;
  logic [30:0] pol_tab [4];
  logic        s_reg [NSLOT], s_en [NSLOT], s_brk [NSLOT], s_flag [NSLOT];
  logic        s_up_ok [NSLOT], s_seen_ok [NSLOT];
  logic [7:0]  s_att [NSLOT];
  logic [47:0] s_restart [NSLOT], s_up_t [NSLOT], s_seen_t [NSLOT];

  req_t pending_cmds [$];
  res_t snapshots_due [$];
  int   errors = 0;
  int   cycles = 0;
  int   sent = 0;
  int   seen_results = 0;
  bit   hold_cmds = 1'b0;
  bit   quiet = 1'b0;
  int   gap_left = 0;

  function automatic logic [30:0] backoff_for(logic [7:0] att);
    int unsigned n, k;
    n = (pol_len == 0) ? 1 : ((pol_len > 4) ? 4 : pol_len);
    k = att - 1;
    if (k >= n) k = n - 1;
    return pol_tab[k];
  endfunction

  function automatic logic [47:0] since(logic [47:0] a, logic [47:0] b);
    return (a >= b) ? a - b : 48'd0;
  endfunction

  function automatic res_t apply_event(req_t r);
    res_t o;
    int s;
    logic [47:0] now;
    logic [30:0] b;
    logic active;
    o = '0;
    s = r.slot;
    now = r.now_ms;
    if (r.req_type == OP_REGISTER) begin
      s_reg[s] = 1'b1; s_en[s] = r.enable_policy; s_att[s] = 0; s_brk[s] = 0;
      s_flag[s] = 0; s_restart[s] = 0; s_up_t[s] = 0; s_up_ok[s] = 0;
      s_seen_t[s] = 0; s_seen_ok[s] = 0;
    end
    if (!s_reg[s]) return o;
    case (r.req_type)
      OP_CRASH: begin
        if (!s_en[s]) begin
          s_brk[s] = 1'b1;
        end else begin
          if (s_att[s] != 8'hFF) s_att[s]++;
          s_up_ok[s] = 1'b0;
          if (s_att[s] > pol_max) begin
            s_brk[s] = 1'b1;
          end else begin
            b = backoff_for(s_att[s]);
            s_restart[s] = (48'(b) > T_MAX - now) ? T_MAX : now + 48'(b);
            o.op_result = 1'b1;
          end
        end
      end
      OP_HEARTBEAT: begin
        if (!s_up_ok[s]) begin
          s_up_t[s] = now; s_up_ok[s] = 1'b1;
        end
        s_seen_t[s] = now; s_seen_ok[s] = 1'b1;
      end
      OP_SUCCESS: begin
        s_att[s] = 0; s_brk[s] = 0; s_flag[s] = 0; s_restart[s] = 0;
      end
      OP_SET_FLAG: begin
        if (!s_flag[s]) begin
          s_flag[s] = 1'b1; o.op_result = 1'b1;
        end
      end
      OP_CLEAR_FLAG: s_flag[s] = 1'b0;
      default: ;
    endcase
    active = (s_att[s] != 0) && !s_brk[s];
    o.known = 1'b1;
    o.policy_enabled = s_en[s];
    o.restart_allowed = s_en[s] && !s_brk[s] && now >= s_restart[s];
    o.breaker_open = s_brk[s];
    o.crash_flag = s_flag[s];
    o.attempts = s_att[s];
    o.backoff_out = active ? backoff_for(s_att[s]) : '0;
    o.mark_recovered = s_en[s] && active && s_up_ok[s] &&
                       since(now, s_up_t[s]) >= 48'(pol_stable_ms);
    o.restart_in_ms = active ? since(s_restart[s], now) : '0;
    o.seen_age_ms = s_seen_ok[s] ? since(now, s_seen_t[s]) : T_MAX;
    o.uptime_s = s_up_ok[s] ? 39'(since(now, s_up_t[s]) / 1000) : '0;
    return o;
  endfunction

  // driver: one command per accepted transfer, random gaps unless quiet is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        snapshots_due.insert(snapshots_due.size(), apply_event(req_i));
        sent++;
      end
      if (start && busy) begin
        // hold the command until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!hold_cmds && pending_cmds.size() > 0 &&
                   !(start && !busy && pending_cmds.size() == 0)) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 7);
          start <= 1'b0;
        end else begin
          req_i <= pending_cmds.pop_front();
          start <= 1'b1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t want;
    cycles++;
    if (rst_ni && res_valid_o) begin
      seen_results++;
      if (snapshots_due.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        want = snapshots_due.pop_front();
        if (res_o !== want) begin
          errors++;
          if (res_o.known !== want.known)
            $error("known exp %0d got %0d", want.known, res_o.known);
          if (res_o.op_result !== want.op_result)
            $error("op_result exp %0d got %0d", want.op_result, res_o.op_result);
          if (res_o.policy_enabled !== want.policy_enabled)
            $error("policy_enabled exp %0d got %0d", want.policy_enabled,
                   res_o.policy_enabled);
          if (res_o.restart_allowed !== want.restart_allowed)
            $error("restart_allowed exp %0d got %0d", want.restart_allowed,
                   res_o.restart_allowed);
          if (res_o.breaker_open !== want.breaker_open)
            $error("breaker_open exp %0d got %0d", want.breaker_open, res_o.breaker_open);
          if (res_o.crash_flag !== want.crash_flag)
            $error("crash_flag exp %0d got %0d", want.crash_flag, res_o.crash_flag);
          if (res_o.attempts !== want.attempts)
            $error("attempts exp %0d got %0d", want.attempts, res_o.attempts);
          if (res_o.backoff_out !== want.backoff_out)
            $error("backoff_out exp %0d got %0d", want.backoff_out, res_o.backoff_out);
          if (res_o.mark_recovered !== want.mark_recovered)
            $error("mark_recovered exp %0d got %0d", want.mark_recovered,
                   res_o.mark_recovered);
          if (res_o.restart_in_ms !== want.restart_in_ms)
            $error("restart_in_ms exp %0d got %0d", want.restart_in_ms,
                   res_o.restart_in_ms);
          if (res_o.seen_age_ms !== want.seen_age_ms)
            $error("seen_age_ms exp %0d got %0d", want.seen_age_ms,
                   res_o.seen_age_ms);
          if (res_o.uptime_s !== want.uptime_s)
            $error("uptime_s exp %0d got %0d", want.uptime_s, res_o.uptime_s);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BITS'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MAX_ATTEMPTS: pol_max = val[7:0];
      REG_SUCCESS_MS:   pol_stable_ms = val;
      REG_BACKOFF_LEN:  pol_len = val[2:0];
      REG_BACKOFF_0:    pol_tab[0] = val[30:0];
      REG_BACKOFF_1:    pol_tab[1] = val[30:0];
      REG_BACKOFF_2:    pol_tab[2] = val[30:0];
      default:          pol_tab[3] = val[30:0];
    endcase
  endtask

  // wait for the block to drain, then for its longest latency
  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    wait (snapshots_due.size() == 0);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic void add_cmd(op_e op, int s, logic [47:0] now, logic en);
    req_t r;
    r.req_type = op; r.slot = 4'(s); r.now_ms = now; r.enable_policy = en;
    pending_cmds.insert(pending_cmds.size(), r);
  endfunction

  logic [47:0] clk_ms [NSLOT];

  // random command: mostly well-formed lifecycles on few slots, some noise
  task automatic random_cmds(int n);
    int s, k;
    logic [47:0] t;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, 15) < 12 ? $urandom_range(0, 5) : $urandom_range(0, 15);
      k = $urandom_range(0, 99);
      clk_ms[s] += $urandom_range(0, 3) == 0 ? 48'($urandom_range(0, 90000))
                                             : 48'($urandom_range(0, 3000));
      t = clk_ms[s];
      if (k < 2) t = 48'({$urandom, $urandom});
      else if (k < 4) t = T_MAX - $urandom_range(0, 5000);
      else if (k < 6) t = clk_ms[s] - $urandom_range(0, 20000);
      if (k < 8) add_cmd(OP_REGISTER, s, t, $urandom_range(0, 5) != 0);
      else if (k < 35) add_cmd(OP_CRASH, s, t, 1'($urandom));
      else if (k < 65) add_cmd(OP_HEARTBEAT, s, t, 1'($urandom));
      else if (k < 75) add_cmd(OP_SUCCESS, s, t, 1'($urandom));
      else if (k < 82) add_cmd(OP_SET_FLAG, s, t, 1'($urandom));
      else if (k < 87) add_cmd(OP_CLEAR_FLAG, s, t, 1'($urandom));
      else if (k < 97) add_cmd(OP_QUERY, s, t, 1'($urandom));
      else pending_cmds.insert(pending_cmds.size(),
                               req_t'({OP_UNDEF, 4'($urandom), t, 1'($urandom)}));
    end
  endtask

  initial begin
    pol_max = 3; pol_stable_ms = 60000; pol_len = 4;
    pol_tab[0] = 100; pol_tab[1] = 1000; pol_tab[2] = 5000; pol_tab[3] = 10000;
    for (int s = 0; s < NSLOT; s++) begin
      s_reg[s] = 0; s_en[s] = 0; s_att[s] = 0; s_brk[s] = 0; s_flag[s] = 0;
      s_restart[s] = 0; s_up_t[s] = 0; s_up_ok[s] = 0; s_seen_t[s] = 0;
      s_seen_ok[s] = 0; clk_ms[s] = 0;
    end
    hold_cmds = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: unknown slot, lifecycle, disabled crash, extremes, time going back
    add_cmd(OP_QUERY, 15, 48'd5, 1'b1);
    add_cmd(OP_CRASH, 15, 48'd5, 1'b1);
    add_cmd(OP_REGISTER, 0, 48'd0, 1'b1);
    add_cmd(OP_HEARTBEAT, 0, 48'd10, 1'b0);
    for (int i = 0; i < 5; i++) add_cmd(OP_CRASH, 0, 48'd100 + i, 1'b0);
    add_cmd(OP_SUCCESS, 0, 48'd200, 1'b0);
    add_cmd(OP_SET_FLAG, 0, 48'd201, 1'b0);
    add_cmd(OP_SET_FLAG, 0, 48'd202, 1'b0);
    add_cmd(OP_CLEAR_FLAG, 0, 48'd203, 1'b0);
    add_cmd(OP_REGISTER, 15, T_MAX - 48'd50, 1'b0);
    add_cmd(OP_CRASH, 15, T_MAX, 1'b0);
    add_cmd(OP_REGISTER, 1, 48'd0, 1'b1);
    add_cmd(OP_HEARTBEAT, 1, T_MAX - 48'd70000, 1'b1);
    add_cmd(OP_CRASH, 1, T_MAX - 48'd20, 1'b1);
    add_cmd(OP_HEARTBEAT, 1, T_MAX - 48'd10, 1'b1);
    add_cmd(OP_QUERY, 1, 48'd3, 1'b1);
    pending_cmds.insert(pending_cmds.size(), req_t'({OP_UNDEF, 4'd1, T_MAX, 1'b1}));
    hold_cmds = 1'b0;
    drain();

    // zero stable window, crash limit of 254 and attempts that saturate at 255
    write_reg(REG_MAX_ATTEMPTS, 32'd254);
    write_reg(REG_SUCCESS_MS, 32'd0);
    write_reg(REG_BACKOFF_LEN, 32'd0);
    write_reg(REG_BACKOFF_0, 32'h7FFF_FFFF);
    add_cmd(OP_REGISTER, 2, 48'd0, 1'b1);
    for (int i = 0; i < 258; i++) add_cmd(OP_CRASH, 2, T_MAX - 48'd5, 1'b1);
    add_cmd(OP_HEARTBEAT, 2, T_MAX, 1'b1);
    drain();

    // several policy settings, each with a random phase
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_MAX_ATTEMPTS, ph == 0 ? 32'd0 : 32'($urandom_range(1, 8)));
      write_reg(REG_SUCCESS_MS, ph == 1 ? 32'hFFFF_FFFF : 32'($urandom_range(0, 100000)));
      write_reg(REG_BACKOFF_LEN, 32'($urandom_range(0, 7)));
      write_reg(REG_BACKOFF_0, 32'($urandom_range(0, 500)));
      write_reg(REG_BACKOFF_1, ph == 2 ? 32'h7FFF_FFFF : 32'($urandom_range(0, 5000)));
      write_reg(REG_BACKOFF_2, 32'($urandom));
      write_reg(REG_BACKOFF_3, ph == 3 ? 32'd0 : 32'($urandom_range(0, 50000)));
      quiet = (ph == 3);
      random_cmds(30);
      if (ph == 1) begin
        wait (pending_cmds.size() == 0);
        hold_cmds = 1'b1;
        wait (snapshots_due.size() == 0);
        hold_cmds = 1'b0;
      end
      random_cmds(30);
      drain();
    end

    $display("covered %0d commands, %0d results, six policy settings", sent, seen_results);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
